/* src/mrc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// response checker. No dependencies.
package mrc_pkg;

   localparam int QUEUE_DEPTH = 4;

   // configuration register indexes
   localparam logic CSR_EXPECTED_SLAVE    = 1'b0;
   localparam logic CSR_EXPECTED_FUNCTION = 1'b1;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;
   localparam logic [7:0] FUNC_WRITE_COIL   = 8'h05;
   localparam logic [7:0] FUNC_WRITE_REG    = 8'h06;
   localparam logic [7:0] FUNC_EXC_FLAG     = 8'h80;

   localparam logic [8:0] LEN_UNKNOWN   = 9'd0;
   localparam logic [8:0] LEN_EXCEPTION = 9'd5;
   localparam logic [8:0] LEN_READ_BASE = 9'd5;
   localparam logic [8:0] LEN_WRITE     = 9'd8;

   // status codes of a result word
   localparam logic [2:0] STATUS_BUSY      = 3'd0;
   localparam logic [2:0] STATUS_OK        = 3'd1;
   localparam logic [2:0] STATUS_EXCEPTION = 3'd2;
   localparam logic [2:0] STATUS_BAD_FUNC  = 3'd3;
   localparam logic [2:0] STATUS_CRC_FAIL  = 3'd4;
   localparam logic [2:0] STATUS_SLAVE_MIS = 3'd5;
   localparam logic [2:0] STATUS_FUNC_MIS  = 3'd6;

   // role of a byte, as decided by the front end
   localparam logic [1:0] KIND_CRC      = 2'd0;
   localparam logic [1:0] KIND_HOLD     = 2'd1;
   localparam logic [1:0] KIND_VERDICT  = 2'd2;
   localparam logic [1:0] KIND_BAD_FUNC = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [8:0] byte_index;
      logic       restart;
      logic [1:0] kind;
   } token_type;

   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* src/mrc_if.sv */
// Valid/ready channel interfaces for the response checker: received bytes
// in, checked result words out. Depends on nothing.
interface mrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       restart;

   modport source (output valid, rx_byte, restart, input ready);
   modport sink   (input valid, rx_byte, restart, output ready);
endinterface

interface mrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [8:0] byte_index;
   logic       last;
   logic [2:0] status;
   logic [7:0] exception_code;

   modport source (output valid, data_byte, byte_index, last, status, exception_code,
                   input ready);
   modport sink   (input valid, data_byte, byte_index, last, status, exception_code,
                   output ready);
endinterface

/* src/mrc_front.sv */
// Front end: accepts received bytes, tracks position and frame length and
// tags each byte with its role. Depends on mrc_pkg and mrc_req_if.
module mrc_front (
   input  logic              clock,
   input  logic              reset,
   mrc_req_if.sink           req_chan,
   input  logic [7:0]        expected_function,
   input  logic              queue_full,
   output logic              push,
   output mrc_pkg::token_type token
);
   import mrc_pkg::*;

   logic [8:0]  position_ff, position_in;
   logic [8:0]  length_ff, length_in;
   logic [8:0]  pos;
   logic [8:0]  len_cur;
   logic [8:0]  len_new;
   logic [9:0]  pos_plus2;
   logic [1:0]  kind;
   logic [7:0]  b;

   assign b = req_chan.rx_byte;
   assign req_chan.ready = !queue_full;
   assign push = req_chan.valid && !queue_full;

   always_comb begin
      pos     = req_chan.restart ? 9'd0 : position_ff;
      len_cur = req_chan.restart ? LEN_UNKNOWN : length_ff;
      len_new = len_cur;
      kind    = KIND_CRC;
      pos_plus2 = {1'b0, pos} + 10'd2;
      if (pos == 9'd0) begin
         kind = KIND_CRC;
      end else if (pos == 9'd1) begin
         if (b == (expected_function | FUNC_EXC_FLAG)) begin
            len_new = LEN_EXCEPTION;
         end else if (b == FUNC_READ_HOLDING || b == FUNC_READ_INPUT) begin
            len_new = LEN_UNKNOWN;
         end else if (b == FUNC_WRITE_COIL || b == FUNC_WRITE_REG) begin
            len_new = LEN_WRITE;
         end else begin
            kind = KIND_BAD_FUNC;
         end
      end else begin
         if (pos == 9'd2 && len_cur == LEN_UNKNOWN) begin
            len_new = LEN_READ_BASE + {1'b0, b};
         end
         if (pos_plus2 < {1'b0, len_new}) begin
            kind = KIND_CRC;
         end else if (pos_plus2 == {1'b0, len_new}) begin
            kind = KIND_HOLD;
         end else begin
            kind = KIND_VERDICT;
         end
      end
   end

   always_comb begin
      position_in = position_ff;
      length_in   = length_ff;
      if (push) begin
         if (kind == KIND_VERDICT || kind == KIND_BAD_FUNC) begin
            // back end halts or the frame is complete; either way start over
            position_in = 9'd0;
            length_in   = LEN_UNKNOWN;
         end else begin
            position_in = pos + 9'd1;
            length_in   = len_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 9'd0;
         length_ff   <= LEN_UNKNOWN;
      end else begin
         position_ff <= position_in;
         length_ff   <= length_in;
      end
   end

   assign token.data_byte  = b;
   assign token.byte_index = pos;
   assign token.restart    = req_chan.restart;
   assign token.kind       = kind;

   a_verdict_late: assert property (@(posedge clock) disable iff (reset)
      push && kind == KIND_VERDICT |-> pos >= 9'd4)
      else $error("verdict tagged before byte 4");

   a_bad_func_pos: assert property (@(posedge clock) disable iff (reset)
      push && kind == KIND_BAD_FUNC |-> pos == 9'd1)
      else $error("bad function tagged off the function byte");

endmodule

/* src/mrc_queue.sv */
// Short FIFO of tagged words between front and back end.
// Depends on mrc_pkg.
module mrc_queue #(
   parameter int DEPTH = mrc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mrc_pkg::token_type push_token,
   input  logic               pop,
   output mrc_pkg::token_type head,
   output logic               empty,
   output logic               full
);
   import mrc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count past depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

/* src/mrc_back.sv */
// Back end: runs the CRC, captures header bytes, forms the verdict and
// drives the registered result channel. Depends on mrc_pkg and mrc_rsp_if.
module mrc_back (
   input  logic               clock,
   input  logic               reset,
   input  mrc_pkg::token_type head,
   input  logic               empty,
   output logic               pop,
   input  logic [7:0]         expected_slave,
   input  logic [7:0]         expected_function,
   mrc_rsp_if.source          rsp_chan
);
   import mrc_pkg::*;

   logic        halted_ff, halted_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held_low_ff, slave_ff, func_ff, code_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_exc_ff;
   logic [8:0]  rsp_index_ff;
   logic        rsp_last_ff;
   logic [2:0]  rsp_status_ff;

   logic        active;
   logic        can_load;
   logic        load;
   logic        reject;
   logic [2:0]  status;
   logic        last;
   logic [7:0]  exc;
   logic [15:0] crc_base;
   logic [15:0] rx_crc;

   // after a rejection, words are dropped until one carries restart
   assign active   = !(halted_ff && !head.restart);
   assign can_load = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = !empty && (!active || can_load);
   assign load     = pop && active;

   assign crc_base = (head.byte_index == 9'd0) ? CRC_INIT : crc_ff;
   assign rx_crc   = {head.data_byte, held_low_ff};

   always_comb begin
      status = STATUS_BUSY;
      last   = 1'b0;
      exc    = 8'h00;
      reject = 1'b0;
      case (head.kind)
         KIND_BAD_FUNC: begin
            status = STATUS_BAD_FUNC;
            last   = 1'b1;
            reject = 1'b1;
         end
         KIND_VERDICT: begin
            last = 1'b1;
            if (crc_ff != rx_crc) begin
               status = STATUS_CRC_FAIL;
               reject = 1'b1;
            end else if (slave_ff != expected_slave) begin
               status = STATUS_SLAVE_MIS;
               reject = 1'b1;
            end else if (func_ff[7]) begin
               status = STATUS_EXCEPTION;
               exc    = code_ff;
            end else if (func_ff != expected_function) begin
               status = STATUS_FUNC_MIS;
               reject = 1'b1;
            end else begin
               status = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      crc_in    = crc_ff;
      halted_in = halted_ff;
      if (pop) begin
         halted_in = (halted_ff && !head.restart) || (active && reject);
      end
      if (load && head.kind == KIND_CRC) begin
         crc_in = crc16_update(crc_base, head.data_byte);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff    <= 1'b0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         halted_ff    <= halted_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (head.byte_index == 9'd0) begin
            slave_ff <= head.data_byte;
         end
         if (head.byte_index == 9'd1) begin
            func_ff <= head.data_byte;
         end
         if (head.byte_index == 9'd2) begin
            code_ff <= head.data_byte;
         end
         if (head.kind == KIND_HOLD) begin
            held_low_ff <= head.data_byte;
         end
         rsp_data_ff   <= head.data_byte;
         rsp_index_ff  <= head.byte_index;
         rsp_last_ff   <= last;
         rsp_status_ff <= status;
         rsp_exc_ff    <= exc;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.data_byte      = rsp_data_ff;
   assign rsp_chan.byte_index     = rsp_index_ff;
   assign rsp_chan.last           = rsp_last_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.exception_code = rsp_exc_ff;

   a_busy_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_status_ff == STATUS_BUSY)
      else $error("status set on a non-final word");

   a_exc_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_exc_ff != 8'h00 |-> rsp_status_ff == STATUS_EXCEPTION)
      else $error("exception code without exception status");

   a_halt_drops: assert property (@(posedge clock) disable iff (reset)
      pop && halted_ff && !head.restart |-> !load)
      else $error("word passed while halted");

endmodule

/* src/modbus_rtu_response_checker_unit.sv */
// Modbus RTU response checker, top level: configuration registers, front
// end, word queue and back end. Depends on mrc_pkg, mrc_if, mrc_front,
// mrc_queue and mrc_back.
// An accepted byte is written into the queue, then its result word is loaded
// into the output register. Throughput: one byte per cycle while the result
// channel takes words; the CRC-16 byte update in the back end is combinational.
// Reset (synchronous, active high) clears parse state, the queue and the
// output register; expected_slave resets to 0, expected_function to 3.
module modbus_rtu_response_checker_unit #(
   parameter int QUEUE_DEPTH = mrc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   mrc_req_if.sink    req_chan,
   mrc_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import mrc_pkg::*;

   logic [7:0] expected_slave_ff, expected_function_ff;
   token_type  push_token;
   token_type  head;
   logic       push, pop, empty, full;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_slave_ff    <= 8'h00;
         expected_function_ff <= FUNC_READ_HOLDING;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPECTED_SLAVE:    expected_slave_ff    <= csr_wdata;
            CSR_EXPECTED_FUNCTION: expected_function_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mrc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_chan          (req_chan),
      .expected_function (expected_function_ff),
      .queue_full        (full),
      .push              (push),
      .token             (push_token)
   );

   mrc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   mrc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .empty             (empty),
      .pop               (pop),
      .expected_slave    (expected_slave_ff),
      .expected_function (expected_function_ff),
      .rsp_chan          (rsp_chan)
   );

endmodule
